@@ rtl/binary_tree_format_walker_top_macros.svh @@
// Assertion macros shared by the checker of the document walker.
`ifndef BINARY_TREE_FORMAT_WALKER_TOP_MACROS_SVH
`define BINARY_TREE_FORMAT_WALKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTFW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTFW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/btfw_pkg.sv @@
// Types, codes and size tables of the document walker.
`default_nettype none
package btfw_pkg;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_HEADER  = 3'd1;
    localparam logic [2:0] ERR_SIZE    = 3'd2;
    localparam logic [2:0] ERR_UNTERM  = 3'd3;
    localparam logic [2:0] ERR_PADDING = 3'd4;
    localparam logic [2:0] ERR_KEY     = 3'd5;
    localparam logic [2:0] ERR_DEPTH   = 3'd6;

    localparam logic [7:0] CFG_WIDE_SIZES    = 8'd0;
    localparam logic [7:0] CFG_BUFFER_LENGTH = 8'd1;

    localparam logic [7:0] TAG_NONE        = 8'd0;
    localparam logic [7:0] TAG_TRUE        = 8'd2;
    localparam logic [7:0] TAG_FALSE       = 8'd3;
    localparam logic [7:0] TAG_INT8        = 8'd4;
    localparam logic [7:0] TAG_LAST_SCALAR = 8'd13;
    localparam logic [7:0] TAG_STRING      = 8'd14;
    localparam logic [7:0] TAG_STR4        = 8'd15;
    localparam logic [7:0] TAG_STR12       = 8'd17;
    localparam logic [7:0] TAG_OBJECT      = 8'd18;
    localparam logic [7:0] TAG_ARRAY       = 8'd19;
    localparam logic [7:0] TAG_LAST        = 8'd29;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_VALUE  = 6'b000010,
        PH_SIZE   = 6'b000100,
        PH_TEXT   = 6'b001000,
        PH_SKIP   = 6'b010000,
        PH_DONE   = 6'b100000
    } btfw_phase_t;

    typedef struct packed {
        logic [4:0]  node_type;
        logic [31:0] node_offset;
        logic [31:0] node_size;
        logic        key_present;
        logic [31:0] key_offset;
        logic [31:0] content_offset;
        logic [31:0] element_count;
        logic [63:0] value_bits;
        logic [4:0]  depth;
        logic        has_children;
        logic [2:0]  error_code;
    } btfw_rec_t;

    typedef struct packed {
        logic        push;
        logic        push_obj;
        logic [31:0] push_end;
        logic        pop;
        logic [32:0] probe;
    } btfw_stack_ctl_t;

    function automatic logic [3:0] min_size(input logic [7:0] tag, input logic wide);
        logic [3:0] r;
        unique case (tag)
            8'd4, 8'd8:                r = 4'd2;
            8'd5, 8'd9:                r = 4'd3;
            8'd6, 8'd10, 8'd12:        r = 4'd5;
            8'd7, 8'd11, 8'd13:        r = 4'd9;
            8'd14:                     r = wide ? 4'd10 : 4'd6;
            8'd15:                     r = 4'd4;
            8'd16:                     r = 4'd8;
            8'd17:                     r = 4'd12;
            8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
            8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29:
                                       r = wide ? 4'd9 : 4'd5;
            default:                   r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] hdr_size(input logic [7:0] tag, input logic wide);
        logic [3:0] r;
        unique case (tag)
            8'd14, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
            8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29:
                     r = wide ? 4'd9 : 4'd5;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    // Log2 of the element size of a typed array.
    function automatic logic [1:0] elem_shift(input logic [7:0] tag);
        logic [1:0] r;
        unique case (tag)
            8'd21, 8'd25:        r = 2'd1;
            8'd22, 8'd26, 8'd28: r = 2'd2;
            8'd23, 8'd27, 8'd29: r = 2'd3;
            default:             r = 2'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/btfw_if.sv @@
// Channel interfaces of the document walker: input bytes, result records, configuration.
`default_nettype none
interface btfw_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface btfw_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  node_type;
    logic [31:0] node_offset;
    logic [31:0] node_size;
    logic        key_present;
    logic [31:0] key_offset;
    logic [31:0] content_offset;
    logic [31:0] element_count;
    logic [63:0] value_bits;
    logic [4:0]  depth;
    logic        has_children;
    logic [2:0]  error_code;
    modport source (output valid, output node_type, output node_offset, output node_size,
                    output key_present, output key_offset, output content_offset,
                    output element_count, output value_bits, output depth,
                    output has_children, output error_code, input ready);
    modport sink (input valid, input node_type, input node_offset, input node_size,
                  input key_present, input key_offset, input content_offset,
                  input element_count, input value_bits, input depth,
                  input has_children, input error_code, output ready);
endinterface

interface btfw_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/btfw_stack.sv @@
// Stack of open containers with end offsets and a parallel pop of finished levels.
`default_nettype none
module btfw_stack #(
    parameter int MAX_DEPTH = 16,
    parameter int LW = $clog2(MAX_DEPTH + 1),
    parameter int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  btfw_pkg::btfw_stack_ctl_t ctl,
    output logic [LW-1:0]            levels,
    output logic [31:0]              top_end,
    output logic                     top_obj,
    output logic [LW-1:0]            kept
);
    import btfw_pkg::*;

    logic [31:0]   end_mem [MAX_DEPTH];
    logic          obj_mem [MAX_DEPTH];
    logic [LW-1:0] levels_reg;
    logic [LW-1:0] levels_next;
    logic [IW-1:0] top_idx;
    logic [IW-1:0] push_idx;

    assign levels   = levels_reg;
    assign top_idx  = IW'(levels_reg - LW'(1));
    assign push_idx = IW'(levels_reg);
    assign top_end  = end_mem[top_idx];
    assign top_obj  = obj_mem[top_idx];

    // Child ends never pass their parent's end, so live levels form the bottom of the stack.
    always_comb
    begin
        kept = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((LW'(i) < levels_reg) && (ctl.probe < {1'b0, end_mem[i]}))
            begin
                kept = kept + LW'(1);
            end
        end
    end

    always_comb
    begin
        levels_next = levels_reg;
        if (ctl.push)
        begin
            levels_next = levels_reg + LW'(1);
        end
        else if (ctl.pop)
        begin
            levels_next = kept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            end_mem[push_idx] <= ctl.push_end;
            obj_mem[push_idx] <= ctl.push_obj;
        end
    end

endmodule
`default_nettype wire

@@ rtl/binary_tree_format_walker_top.sv @@
// Top level of the streaming walker for tagged binary documents.
//   channel  direction  payload
//   src      in         data_byte, one document byte per item
//   res      out        one decoded entity record per item
//   cfg      in         index and data of a register write
// Every byte is decoded in the cycle it is accepted, so one item per cycle is sustained unless src stalls.
// A record goes into an output register; src stalls only while that register is full
// and not taken. Reset clears the walk state and the registers; the open-container
// stack entries need no clearing. After an error or the end of the root, bytes are dropped.
`default_nettype none
module binary_tree_format_walker_top #(
    parameter int MAX_DEPTH = 16
) (
    input wire        clk,
    input wire        rst_n,
    btfw_src_if.sink  src,
    btfw_res_if.source res,
    btfw_cfg_if.sink  cfg
);
    import btfw_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);

    logic        wide_reg;
    logic [31:0] buflen_reg;
    logic [31:0] byte_offset_reg, byte_offset_next;
    logic [31:0] entity_start_reg, entity_start_next;
    logic [7:0]  header_tag_reg, header_tag_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [3:0]  target_reg, target_next;
    logic [63:0] gathered_reg, gathered_next;
    btfw_phase_t phase_reg, phase_next;
    logic [31:0] pks_reg, pks_next;
    logic [31:0] pksize_reg, pksize_next;
    logic [31:0] key_text_reg, key_text_next;
    logic        halted_reg, halted_next;
    logic        in_value_reg, in_value_next;
    logic        zero_seen_reg, zero_seen_next;
    logic [3:0]  text_len_reg, text_len_next;
    logic [3:0]  ent_min_reg, ent_min_next;
    logic [3:0]  ent_hdr_reg, ent_hdr_next;
    logic [31:0] ent_end_reg, ent_end_next;
    logic [31:0] ent_size_reg, ent_size_next;
    logic        out_valid_reg;
    btfw_rec_t   rec_reg;

    btfw_stack_ctl_t stk;
    logic [LW-1:0]   levels;
    logic [LW-1:0]   kept;
    logic [31:0]     top_end;
    logic            top_obj;

    logic        fire;
    logic [7:0]  b;
    logic [32:0] nxt;
    logic [31:0] pend;
    logic        keyexp;
    logic [3:0]  mn;
    logic [3:0]  hd;
    logic [31:0] room;
    logic [63:0] g;
    logic [3:0]  fbc1;
    logic [63:0] v;
    logic [1:0]  esh;
    logic [31:0] pad;
    logic [31:0] emask;
    logic        kids;
    logic        do_emit;
    logic        do_fail;
    logic        do_finish;
    logic [2:0]  fail_code;
    logic [7:0]  e_type;
    logic [31:0] e_size;
    logic [31:0] e_content;
    logic [31:0] e_count;
    logic [63:0] e_value;
    logic        e_kids;
    btfw_rec_t   rec;

    btfw_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk),
        .levels  (levels),
        .top_end (top_end),
        .top_obj (top_obj),
        .kept    (kept)
    );

    assign src.ready = !out_valid_reg || res.ready;
    assign cfg.ready = 1'b1;
    assign fire      = src.valid && src.ready;
    assign b         = src.data_byte;
    assign nxt       = {1'b0, byte_offset_reg} + 33'd1;
    assign pend      = (levels == '0) ? buflen_reg : top_end;
    assign keyexp    = (levels != '0) && top_obj && !in_value_reg;

    always_comb
    begin
        byte_offset_next  = byte_offset_reg;
        entity_start_next = entity_start_reg;
        header_tag_next   = header_tag_reg;
        fbc_next          = fbc_reg;
        target_next       = target_reg;
        gathered_next     = gathered_reg;
        phase_next        = phase_reg;
        pks_next          = pks_reg;
        pksize_next       = pksize_reg;
        key_text_next     = key_text_reg;
        halted_next       = halted_reg;
        in_value_next     = in_value_reg;
        zero_seen_next    = zero_seen_reg;
        text_len_next     = text_len_reg;
        ent_min_next      = ent_min_reg;
        ent_hdr_next      = ent_hdr_reg;
        ent_end_next      = ent_end_reg;
        ent_size_next     = ent_size_reg;
        stk               = '0;
        stk.probe         = nxt;
        mn                = min_size(b, wide_reg);
        hd                = hdr_size(b, wide_reg);
        room              = '0;
        g                 = gathered_reg | (64'(b) << {fbc_reg[2:0], 3'b000});
        fbc1              = fbc_reg + 4'd1;
        v                 = g;
        esh               = elem_shift(header_tag_reg);
        emask             = (32'd1 << esh) - 32'd1;
        pad               = '0;
        kids              = 1'b0;
        do_emit           = 1'b0;
        do_fail           = 1'b0;
        do_finish         = 1'b0;
        fail_code         = ERR_NONE;
        e_type            = header_tag_reg;
        e_size            = '0;
        e_content         = '0;
        e_count           = '0;
        e_value           = '0;
        e_kids            = 1'b0;

        if (fire && !halted_reg && (phase_reg != PH_DONE))
        begin
            byte_offset_next = nxt[31:0];
            unique case (phase_reg)
                PH_HEADER:
                begin
                    entity_start_next = byte_offset_reg;
                    header_tag_next   = b;
                    room = (pend > byte_offset_reg) ? pend - byte_offset_reg : '0;
                    if ((b == TAG_NONE) || (b > TAG_LAST))
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_HEADER;
                    end
                    else if ({28'd0, mn} > room)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_SIZE;
                    end
                    else if ((b <= TAG_LAST_SCALAR) && keyexp)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_KEY;
                    end
                    else
                    begin
                        ent_min_next = mn;
                        ent_hdr_next = hd;
                        if (b <= TAG_FALSE)
                        begin
                            do_emit   = 1'b1;
                            do_finish = 1'b1;
                            e_type    = b;
                            e_size    = 32'd1;
                            e_value   = (b == TAG_TRUE) ? 64'd1 : 64'd0;
                        end
                        else
                        begin
                            gathered_next = '0;
                            fbc_next      = '0;
                            if (b <= TAG_LAST_SCALAR)
                            begin
                                target_next = mn - 4'd1;
                                phase_next  = PH_VALUE;
                            end
                            else if ((b >= TAG_STR4) && (b <= TAG_STR12))
                            begin
                                ent_size_next  = {28'd0, mn};
                                ent_end_next   = byte_offset_reg + {28'd0, mn};
                                text_len_next  = '0;
                                zero_seen_next = 1'b0;
                                phase_next     = PH_TEXT;
                            end
                            else
                            begin
                                target_next = hd - 4'd1;
                                phase_next  = PH_SIZE;
                            end
                        end
                    end
                end
                PH_VALUE:
                begin
                    gathered_next = g;
                    fbc_next      = fbc1;
                    if (fbc1 >= target_reg)
                    begin
                        if ((header_tag_reg == TAG_INT8) && g[7])
                        begin
                            v = {56'hFF_FFFF_FFFF_FFFF, g[7:0]};
                        end
                        do_emit   = 1'b1;
                        do_finish = 1'b1;
                        e_size    = {28'd0, ent_min_reg};
                        e_value   = v;
                    end
                end
                PH_SIZE:
                begin
                    gathered_next = g;
                    fbc_next      = fbc1;
                    room = (pend > entity_start_reg) ? pend - entity_start_reg : '0;
                    kids = g > {60'd0, ent_hdr_reg};
                    if (fbc1 >= target_reg)
                    begin
                        ent_size_next = g[31:0];
                        ent_end_next  = entity_start_reg + g[31:0];
                        if ((g > {32'd0, room}) || (g < {60'd0, ent_min_reg}))
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_SIZE;
                        end
                        else if (header_tag_reg == TAG_STRING)
                        begin
                            phase_next = PH_TEXT;
                        end
                        else if ((header_tag_reg == TAG_OBJECT) ||
                                 (header_tag_reg == TAG_ARRAY))
                        begin
                            if (keyexp)
                            begin
                                do_fail   = 1'b1;
                                fail_code = ERR_KEY;
                            end
                            else if (kids && (levels >= LW'(MAX_DEPTH)))
                            begin
                                do_fail   = 1'b1;
                                fail_code = ERR_DEPTH;
                            end
                            else
                            begin
                                do_emit = 1'b1;
                                e_size  = g[31:0];
                                e_kids  = kids;
                                if (kids)
                                begin
                                    stk.push     = 1'b1;
                                    stk.push_obj = (header_tag_reg == TAG_OBJECT);
                                    stk.push_end = entity_start_reg + g[31:0];
                                    phase_next   = PH_HEADER;
                                end
                                else
                                begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (kids)
                            begin
                                pad = (32'd0 - entity_start_reg) & emask;
                            end
                            if (kids && ((({28'd0, ent_hdr_reg}) + pad) > g[31:0]))
                            begin
                                do_fail   = 1'b1;
                                fail_code = ERR_PADDING;
                            end
                            else if (keyexp)
                            begin
                                do_fail   = 1'b1;
                                fail_code = ERR_KEY;
                            end
                            else
                            begin
                                do_emit   = 1'b1;
                                e_size    = g[31:0];
                                e_content = entity_start_reg + {28'd0, ent_hdr_reg} + pad;
                                if (kids)
                                begin
                                    e_count = (g[31:0] - {28'd0, ent_hdr_reg} - pad) >> esh;
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_TEXT:
                begin
                    if (!zero_seen_reg)
                    begin
                        if (b == 8'd0)
                        begin
                            zero_seen_next = 1'b1;
                        end
                        else
                        begin
                            text_len_next = text_len_reg + 4'd1;
                        end
                    end
                    if (nxt >= {1'b0, ent_end_reg})
                    begin
                        if (b != 8'd0)
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_UNTERM;
                        end
                        else if (keyexp)
                        begin
                            pks_next      = entity_start_reg;
                            pksize_next   = ent_size_reg;
                            key_text_next = entity_start_reg + {28'd0, ent_hdr_reg};
                            in_value_next = 1'b1;
                            phase_next    = PH_HEADER;
                        end
                        else
                        begin
                            do_emit   = 1'b1;
                            do_finish = 1'b1;
                            e_size    = ent_size_reg;
                            e_content = entity_start_reg + {28'd0, ent_hdr_reg};
                            e_count   = (header_tag_reg == TAG_STRING) ?
                                        ent_size_reg - {28'd0, ent_hdr_reg} - 32'd1 :
                                        {28'd0, text_len_next};
                        end
                    end
                end
                PH_SKIP:
                begin
                    do_finish = nxt >= {1'b0, ent_end_reg};
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (do_finish)
            begin
                stk.pop    = 1'b1;
                phase_next = (kept == '0) ? PH_DONE : PH_HEADER;
            end
            if (do_emit)
            begin
                in_value_next = 1'b0;
            end
            if (do_fail)
            begin
                halted_next = 1'b1;
            end
        end

        rec = '0;
        if (do_fail)
        begin
            rec.node_type   = ((header_tag_next >= 8'd1) && (header_tag_next <= TAG_LAST)) ?
                              header_tag_next[4:0] : 5'd0;
            rec.node_offset = entity_start_next;
            rec.depth       = 5'(levels);
            rec.error_code  = fail_code;
        end
        else
        begin
            rec.node_type      = e_type[4:0];
            rec.node_offset    = in_value_reg ? pks_reg : entity_start_next;
            rec.node_size      = e_size + (in_value_reg ? pksize_reg : 32'd0);
            rec.key_present    = in_value_reg;
            rec.key_offset     = in_value_reg ? key_text_reg : 32'd0;
            rec.content_offset = e_content;
            rec.element_count  = e_count;
            rec.value_bits     = e_value;
            rec.depth          = 5'(levels);
            rec.has_children   = e_kids;
            rec.error_code     = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg         <= 1'b0;
            buflen_reg       <= '0;
            byte_offset_reg  <= '0;
            entity_start_reg <= '0;
            header_tag_reg   <= '0;
            fbc_reg          <= '0;
            target_reg       <= '0;
            gathered_reg     <= '0;
            phase_reg        <= PH_HEADER;
            pks_reg          <= '0;
            pksize_reg       <= '0;
            key_text_reg     <= '0;
            halted_reg       <= 1'b0;
            in_value_reg     <= 1'b0;
            zero_seen_reg    <= 1'b0;
            text_len_reg     <= '0;
            ent_min_reg      <= '0;
            ent_hdr_reg      <= '0;
            ent_end_reg      <= '0;
            ent_size_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && (cfg.index == CFG_WIDE_SIZES))
            begin
                wide_reg <= cfg.data[0];
            end
            if (cfg.valid && (cfg.index == CFG_BUFFER_LENGTH))
            begin
                buflen_reg <= cfg.data;
            end
            byte_offset_reg  <= byte_offset_next;
            entity_start_reg <= entity_start_next;
            header_tag_reg   <= header_tag_next;
            fbc_reg          <= fbc_next;
            target_reg       <= target_next;
            gathered_reg     <= gathered_next;
            phase_reg        <= phase_next;
            pks_reg          <= pks_next;
            pksize_reg       <= pksize_next;
            key_text_reg     <= key_text_next;
            halted_reg       <= halted_next;
            in_value_reg     <= in_value_next;
            zero_seen_reg    <= zero_seen_next;
            text_len_reg     <= text_len_next;
            ent_min_reg      <= ent_min_next;
            ent_hdr_reg      <= ent_hdr_next;
            ent_end_reg      <= ent_end_next;
            ent_size_reg     <= ent_size_next;
            if (do_emit || do_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit || do_fail)
        begin
            rec_reg <= rec;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.node_type      = rec_reg.node_type;
    assign res.node_offset    = rec_reg.node_offset;
    assign res.node_size      = rec_reg.node_size;
    assign res.key_present    = rec_reg.key_present;
    assign res.key_offset     = rec_reg.key_offset;
    assign res.content_offset = rec_reg.content_offset;
    assign res.element_count  = rec_reg.element_count;
    assign res.value_bits     = rec_reg.value_bits;
    assign res.depth          = rec_reg.depth;
    assign res.has_children   = rec_reg.has_children;
    assign res.error_code     = rec_reg.error_code;

endmodule
`default_nettype wire

@@ rtl/btfw_checker.sv @@
// Port-level checker of the document walker and its bind to the top level.
`default_nettype none
`include "binary_tree_format_walker_top_macros.svh"
module btfw_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] node_offset,
    input wire [31:0] node_size,
    input wire        key_present,
    input wire [31:0] key_offset,
    input wire [63:0] value_bits,
    input wire [2:0]  error_code
);
    import btfw_pkg::*;

    `BTFW_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(node_offset) && $stable(error_code), "Stalled item changed.")
    `BTFW_ASSERT_NOW(a_err_clean, out_valid && (error_code != ERR_NONE), !key_present && (node_size == 32'd0) && (value_bits == 64'd0), "Error item carries data.")
    `BTFW_ASSERT_NEXT(a_halt_after_err, out_valid && out_ready && (error_code != ERR_NONE), !out_valid, "Item after an error.")
    `BTFW_ASSERT_NOW(a_key_order, out_valid && key_present, key_offset > node_offset, "Key text before pair start.")

endmodule

bind binary_tree_format_walker_top btfw_checker u_btfw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .node_offset (res.node_offset),
    .node_size   (res.node_size),
    .key_present (res.key_present),
    .key_offset  (res.key_offset),
    .value_bits  (res.value_bits),
    .error_code  (res.error_code)
);
`default_nettype wire

@@ verif/btfw_checker.sv @@
// Checker that predicts the walker's records from the bytes and compares the records it emits.
module btfw_tb_checker
    import btfw_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input logic  clk,
    input logic  rst_n,
    btfw_src_if  src,
    btfw_res_if  res,
    btfw_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);

    btfw_rec_t   expected_recs[$];

    logic        wide;
    logic [31:0] buf_len;
    logic [31:0] byte_pos;
    logic [63:0] ent_start;
    logic [7:0]  tag;
    logic [3:0]  field_cnt;
    logic [63:0] gathered;
    btfw_phase_t phase;
    logic [63:0] level_end [MAX_DEPTH];
    logic        level_obj [MAX_DEPTH];
    int          levels;
    logic [63:0] key_start;
    logic [63:0] key_size;
    logic [63:0] key_text;
    logic        halted;
    logic        in_value;
    logic        zero_seen;
    int          field_goal;
    int          ent_min;
    int          ent_hdr;
    logic [63:0] ent_end;
    logic [63:0] ent_size;
    logic [63:0] text_len;

    initial fail_count = 0;

    function automatic int min_of(input logic [7:0] t, input logic w);
        case (t)
            4, 8:        return 2;
            5, 9:        return 3;
            6, 10, 12:   return 5;
            7, 11, 13:   return 9;
            TAG_STRING:  return w ? 10 : 6;
            TAG_STR4:    return 4;
            TAG_STR4 + 1: return 8;
            TAG_STR12:   return 12;
            default:     return (t >= TAG_OBJECT && t <= TAG_LAST) ? (w ? 9 : 5) : 1;
        endcase
    endfunction

    function automatic int hdr_of(input logic [7:0] t, input logic w);
        if (t == TAG_STRING || (t >= TAG_OBJECT && t <= TAG_LAST))
            return w ? 9 : 5;
        return 1;
    endfunction

    function automatic int elem_of(input logic [7:0] t);
        case (t)
            20, 24:     return 1;
            21, 25:     return 2;
            22, 26, 28: return 4;
            23, 27, 29: return 8;
            default:    return 0;
        endcase
    endfunction

    function automatic logic [63:0] room_end();
        return levels == 0 ? {32'd0, buf_len} : level_end[levels - 1];
    endfunction

    function automatic void post(input logic [7:0] t, input logic [63:0] size,
                                 input logic [63:0] content, input logic [63:0] count,
                                 input logic [63:0] value, input logic kids);
        btfw_rec_t r;
        logic [63:0] total;
        total = size + (in_value ? key_size : 64'd0);
        r.node_type      = t[4:0];
        r.node_offset    = in_value ? key_start[31:0] : ent_start[31:0];
        r.node_size      = total[31:0];
        r.key_present    = in_value;
        r.key_offset     = in_value ? key_text[31:0] : 32'd0;
        r.content_offset = content[31:0];
        r.element_count  = count[31:0];
        r.value_bits     = value;
        r.depth          = levels[4:0];
        r.has_children   = kids;
        r.error_code     = ERR_NONE;
        in_value = 1'b0;
        expected_recs.push_back(r);
    endfunction

    function automatic void post_error(input logic [2:0] code);
        btfw_rec_t r;
        r = '0;
        r.node_type   = (tag >= 1 && tag <= TAG_LAST) ? tag[4:0] : 5'd0;
        r.node_offset = ent_start[31:0];
        r.depth       = levels[4:0];
        r.error_code  = code;
        halted = 1'b1;
        expected_recs.push_back(r);
    endfunction

    function automatic void close_levels(input logic [63:0] nxt);
        while (levels > 0 && nxt >= level_end[levels - 1])
            levels--;
        phase = levels == 0 ? PH_DONE : PH_HEADER;
    endfunction

    task automatic clear_walk();
        wide = 1'b0;
        buf_len = '0;
        byte_pos = '0;
        ent_start = '0;
        tag = '0;
        field_cnt = '0;
        gathered = '0;
        phase = PH_HEADER;
        levels = 0;
        key_start = '0;
        key_size = '0;
        key_text = '0;
        halted = 1'b0;
        in_value = 1'b0;
        zero_seen = 1'b0;
        field_goal = 0;
        ent_min = 0;
        ent_hdr = 0;
        ent_end = '0;
        ent_size = '0;
        text_len = '0;
        expected_recs.delete();
    endtask

    task automatic walk_byte(input logic [7:0] b);
        logic [63:0] off;
        logic [63:0] nxt;
        logic [63:0] lim;
        logic [63:0] room;
        logic [63:0] v;
        logic [63:0] pad;
        logic [63:0] cnt;
        logic        key_wanted;
        logic        kids;
        int          eb;
        off = {32'd0, byte_pos};
        nxt = off + 64'd1;
        key_wanted = levels > 0 && level_obj[levels - 1] && !in_value;
        if (halted || phase == PH_DONE)
            return;
        byte_pos = nxt[31:0];
        case (phase)
            PH_HEADER:
            begin
                ent_start = off;
                tag = b;
                if (b == TAG_NONE || b > TAG_LAST)
                begin
                    post_error(ERR_HEADER);
                    return;
                end
                ent_min = min_of(b, wide);
                ent_hdr = hdr_of(b, wide);
                lim = room_end();
                room = lim > off ? lim - off : 64'd0;
                if (ent_min > room)
                begin
                    post_error(ERR_SIZE);
                    return;
                end
                if (b <= TAG_LAST_SCALAR && key_wanted)
                begin
                    post_error(ERR_KEY);
                    return;
                end
                if (b <= TAG_FALSE)
                begin
                    post(b, 64'd1, 64'd0, 64'd0, (b == TAG_TRUE) ? 64'd1 : 64'd0, 1'b0);
                    close_levels(nxt);
                    return;
                end
                gathered = '0;
                field_cnt = '0;
                if (b <= TAG_LAST_SCALAR)
                begin
                    field_goal = ent_min - 1;
                    phase = PH_VALUE;
                end
                else if (b >= TAG_STR4 && b <= TAG_STR12)
                begin
                    ent_size = 64'(ent_min);
                    ent_end = off + 64'(ent_min);
                    text_len = '0;
                    zero_seen = 1'b0;
                    phase = PH_TEXT;
                end
                else
                begin
                    field_goal = ent_hdr - 1;
                    phase = PH_SIZE;
                end
            end
            PH_VALUE:
            begin
                gathered |= {56'd0, b} << (8 * field_cnt);
                field_cnt = field_cnt + 4'd1;
                if (field_cnt < field_goal)
                    return;
                v = gathered;
                if (tag == TAG_INT8 && v[7])
                    v[63:8] = '1;
                post(tag, 64'(ent_min), 64'd0, 64'd0, v, 1'b0);
                close_levels(nxt);
            end
            PH_SIZE:
            begin
                gathered |= {56'd0, b} << (8 * field_cnt);
                field_cnt = field_cnt + 4'd1;
                if (field_cnt < field_goal)
                    return;
                lim = room_end();
                room = lim > ent_start ? lim - ent_start : 64'd0;
                if (gathered > room || gathered < ent_min)
                begin
                    post_error(ERR_SIZE);
                    return;
                end
                ent_size = gathered;
                ent_end = ent_start + gathered;
                if (tag == TAG_STRING)
                begin
                    phase = PH_TEXT;
                    return;
                end
                if (tag == TAG_OBJECT || tag == TAG_ARRAY)
                begin
                    kids = ent_size > ent_hdr;
                    if (key_wanted)
                    begin
                        post_error(ERR_KEY);
                        return;
                    end
                    if (kids && levels >= MAX_DEPTH)
                    begin
                        post_error(ERR_DEPTH);
                        return;
                    end
                    post(tag, ent_size, 64'd0, 64'd0, 64'd0, kids);
                    if (kids)
                    begin
                        level_end[levels] = ent_end;
                        level_obj[levels] = (tag == TAG_OBJECT);
                        levels++;
                        phase = PH_HEADER;
                    end
                    else
                        close_levels(nxt);
                    return;
                end
                eb = elem_of(tag);
                pad = '0;
                cnt = '0;
                if (ent_size > ent_hdr && eb != 0)
                begin
                    pad = eb <= 1 ? 64'd0 : (eb - ent_start % eb) % eb;
                    if (ent_hdr + pad > ent_size)
                    begin
                        post_error(ERR_PADDING);
                        return;
                    end
                    cnt = (ent_size - ent_hdr - pad) / eb;
                end
                if (key_wanted)
                begin
                    post_error(ERR_KEY);
                    return;
                end
                post(tag, ent_size, ent_start + ent_hdr + pad, cnt, 64'd0, 1'b0);
                if (ent_size > ent_hdr)
                    phase = PH_SKIP;
                else
                    close_levels(nxt);
            end
            PH_TEXT:
            begin
                if (!zero_seen)
                begin
                    if (b == 8'd0)
                        zero_seen = 1'b1;
                    else
                        text_len++;
                end
                if (nxt < ent_end)
                    return;
                if (b != 8'd0)
                begin
                    post_error(ERR_UNTERM);
                    return;
                end
                if (key_wanted)
                begin
                    key_start = ent_start;
                    key_size = ent_size;
                    key_text = ent_start + ent_hdr;
                    in_value = 1'b1;
                    phase = PH_HEADER;
                    return;
                end
                post(tag, ent_size, ent_start + ent_hdr,
                     tag == TAG_STRING ? ent_size - ent_hdr - 1 : text_len, 64'd0, 1'b0);
                close_levels(nxt);
            end
            PH_SKIP:
            begin
                if (nxt >= ent_end)
                    close_levels(nxt);
            end
            default:
                phase = PH_DONE;
        endcase
    endtask

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_record();
        btfw_rec_t e;
        if (expected_recs.size() == 0)
        begin
            report($sformatf("record at offset %0h with nothing expected", res.node_offset));
            return;
        end
        e = expected_recs.pop_front();
        check_field("node_type", res.node_type, e.node_type);
        check_field("node_offset", res.node_offset, e.node_offset);
        check_field("node_size", res.node_size, e.node_size);
        check_field("key_present", res.key_present, e.key_present);
        check_field("key_offset", res.key_offset, e.key_offset);
        check_field("content_offset", res.content_offset, e.content_offset);
        check_field("element_count", res.element_count, e.element_count);
        check_field("value_bits", res.value_bits, e.value_bits);
        check_field("depth", res.depth, e.depth);
        check_field("has_children", res.has_children, e.has_children);
        check_field("error_code", res.error_code, e.error_code);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_walk();
        else
        begin
            if (res.valid && res.ready)
                check_record();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_WIDE_SIZES)
                    wide = cfg.data[0];
                else if (cfg.index == CFG_BUFFER_LENGTH)
                    buf_len = cfg.data;
            end
            if (src.valid && src.ready)
                walk_byte(src.data_byte);
        end
        pending = expected_recs.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top: builds a document, streams it into the walker and gives the verdict.
module tb;
    import btfw_pkg::*;

    localparam logic [7:0] TAG_NULL = 8'd1;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   gaps_on = 1'b0;
    bit   hold_long = 1'b0;

    logic [7:0] doc[$];
    int         seg_end[$];
    bit         seg_wide[$];
    bit         seg_quiet[$];
    bit         gw;

    btfw_src_if src();
    btfw_res_if res();
    btfw_cfg_if cfg();

    binary_tree_format_walker_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .res   (res),
        .cfg   (cfg)
    );

    btfw_tb_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src),
        .res        (res),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int size_bytes();
        return gw ? 8 : 4;
    endfunction

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            doc.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void patch_size(input int start, input int n);
        logic [63:0] sz;
        sz = 64'(doc.size() - start);
        for (int i = 0; i < n; i++)
            doc[start + 1 + i] = sz[8 * i +: 8];
    endfunction

    function automatic logic [7:0] pick_byte(input int mode);
        case (mode)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void gen_scalar(input logic [7:0] t, input int mode);
        int n;
        doc.push_back(t);
        case (t)
            4, 8:      n = 1;
            5, 9:      n = 2;
            6, 10, 12: n = 4;
            7, 11, 13: n = 8;
            default:   n = 0;
        endcase
        for (int i = 0; i < n; i++)
            doc.push_back((mode == 2 && i < n - 1) ? 8'h00 : pick_byte(mode));
    endfunction

    function automatic void gen_string(input logic [7:0] t);
        int len;
        if (t == TAG_STRING)
        begin
            len = $urandom_range(0, 9);
            doc.push_back(t);
            put_le(64'(size_bytes() + 2 + len), size_bytes());
            for (int i = 0; i < len; i++)
                doc.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            len = (t == TAG_STR4) ? 2 : (t == TAG_STR12) ? 10 : 6;
            doc.push_back(t);
            for (int i = 0; i < len; i++)
                doc.push_back(($urandom_range(0, 2) == 0) ? 8'h00 :
                              8'($urandom_range(1, 255)));
        end
        doc.push_back(8'h00);
    endfunction

    function automatic void gen_typed(input logic [7:0] t);
        int start, eb, hdr, n, extra, pad, sz;
        start = doc.size();
        case (t)
            20, 24:     eb = 1;
            21, 25:     eb = 2;
            22, 26, 28: eb = 4;
            default:    eb = 8;
        endcase
        hdr = size_bytes() + 1;
        n = $urandom_range(0, 5);
        extra = $urandom_range(0, eb - 1);
        pad = (eb - (start % eb)) % eb;
        sz = (n == 0 && extra == 0) ? hdr : hdr + pad + n * eb + extra;
        doc.push_back(t);
        put_le(64'(sz), size_bytes());
        for (int i = hdr; i < sz; i++)
            doc.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void gen_value(input int lvl);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 || (r >= 8 && lvl <= 0))
            gen_scalar(8'($urandom_range(TAG_NULL, TAG_LAST_SCALAR)), $urandom_range(0, 5));
        else if (r < 6)
            gen_string(8'($urandom_range(TAG_STRING, TAG_STR12)));
        else if (r < 8)
            gen_typed(8'($urandom_range(TAG_ARRAY + 1, TAG_LAST)));
        else
            gen_container(r == 8 ? TAG_OBJECT : TAG_ARRAY, lvl - 1);
    endfunction

    function automatic void gen_container(input logic [7:0] t, input int lvl);
        int start, kids;
        start = doc.size();
        doc.push_back(t);
        put_le(64'd0, size_bytes());
        kids = (lvl >= 0) ? $urandom_range(0, 4) : 0;
        for (int k = 0; k < kids; k++)
        begin
            if (t == TAG_OBJECT)
                gen_string(8'($urandom_range(TAG_STRING, TAG_STR12)));
            gen_value(lvl);
        end
        patch_size(start, size_bytes());
    endfunction

    function automatic void gen_chain(input int k);
        int start;
        start = doc.size();
        doc.push_back(TAG_ARRAY);
        put_le(64'd0, size_bytes());
        if (k > 0)
            gen_chain(k - 1);
        patch_size(start, size_bytes());
    endfunction

    function automatic void close_segment(input bit quiet);
        seg_end.push_back(doc.size());
        seg_wide.push_back(gw);
        seg_quiet.push_back(quiet);
    endfunction

    function automatic void gen_fault(input int kind);
        int start;
        case (kind)
            1: doc.push_back($urandom_range(0, 1) ? TAG_NONE : 8'($urandom_range(30, 255)));
            2:
            begin
                doc.push_back(TAG_ARRAY);
                put_le(64'hFFFF_FFF0, size_bytes());
            end
            3:
            begin
                doc.push_back(8'(TAG_STR4 + 1));
                for (int i = 0; i < 6; i++)
                    doc.push_back(8'($urandom_range(0, 255)));
                doc.push_back(8'($urandom_range(1, 255)));
            end
            4:
            begin
                while (doc.size() % 8 == 0 || doc.size() % 8 == 7)
                    doc.push_back(TAG_NULL);
                doc.push_back(TAG_LAST);
                put_le(64'(size_bytes() + 2), size_bytes());
                doc.push_back(8'($urandom_range(0, 255)));
            end
            5:
            begin
                doc.push_back(TAG_OBJECT);
                put_le(64'(size_bytes() + 3), size_bytes());
                doc.push_back(TAG_INT8);
                doc.push_back(8'($urandom_range(0, 255)));
            end
            6: gen_chain(16);
            7:
            begin
                start = doc.size();
                doc.push_back(TAG_OBJECT);
                put_le(64'd0, size_bytes());
                gen_string(TAG_STR4);
                patch_size(start, size_bytes());
                doc.push_back(TAG_NULL);
            end
            default: ;
        endcase
    endfunction

    function automatic void build_document();
        int start;
        gw = 1'b0;
        doc.push_back(TAG_ARRAY);
        put_le(64'd0, 4);
        for (int t = TAG_NULL; t <= TAG_LAST_SCALAR; t++)
            gen_scalar(8'(t), (t % 2) ? 1 : 2);
        gen_scalar(TAG_INT8, 0);
        for (int t = TAG_STRING; t <= TAG_STR12; t++)
            gen_string(8'(t));
        for (int t = TAG_ARRAY + 1; t <= TAG_LAST; t++)
            gen_typed(8'(t));
        gen_container(TAG_OBJECT, -1);
        gen_container(TAG_ARRAY, -1);
        start = doc.size();
        doc.push_back(TAG_OBJECT);
        put_le(64'd0, 4);
        for (int t = TAG_STRING; t <= TAG_STR12; t++)
        begin
            gen_string(8'(t));
            gen_scalar(TAG_TRUE, 3);
        end
        patch_size(start, 4);
        gen_chain(15);
        close_segment(1'b0);
        gw = 1'b1;
        for (int t = TAG_STRING; t <= TAG_STR12; t++)
            gen_string(8'(t));
        for (int t = TAG_ARRAY + 1; t <= TAG_LAST; t++)
            gen_typed(8'(t));
        gen_container(TAG_OBJECT, 2);
        gen_container(TAG_ARRAY, 2);
        close_segment(1'b0);
        while (doc.size() < 1800)
        begin
            gw = $urandom_range(0, 1);
            repeat ($urandom_range(2, 8))
                gen_value(3);
            close_segment($urandom_range(0, 3) == 0);
        end
        gw = $urandom_range(0, 1);
        gen_fault($urandom_range(0, 7));
        for (int i = 0; i < 4; i++)
            doc[1 + i] = 8'(doc.size() >> (8 * i));
        repeat (16)
            doc.push_back(8'($urandom_range(0, 255)));
        close_segment(1'b1);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            src.valid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(negedge clk);
        end
        src.valid <= 1'b1;
        src.data_byte <= b;
        forever
        begin
            @(posedge clk);
            if (src.ready)
                break;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        src.valid <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pending == 0)
                break;
        end
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
                break;
        end
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                res.ready <= 1'b0;
                repeat (300)
                    @(negedge clk);
                hold_long = 1'b0;
                res.ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 17))
                    @(negedge clk);
                res.ready <= 1'b1;
            end
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        int pos;
        src.valid <= 1'b0;
        src.data_byte <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        build_document();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_reg(CFG_WIDE_SIZES, 32'd0);
        write_reg(CFG_BUFFER_LENGTH, 32'hFFFF_FFFF);
        pos = 0;
        for (int s = 0; s < seg_end.size(); s++)
        begin
            if (s > 0)
            begin
                settle();
                write_reg(CFG_WIDE_SIZES, {31'd0, seg_wide[s]});
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_BUFFER_LENGTH, 32'd0);
                    1: write_reg(CFG_BUFFER_LENGTH, 32'hFFFF_FFFF);
                    2: write_reg(CFG_BUFFER_LENGTH, $urandom);
                    default: ;
                endcase
            end
            gaps_on = !seg_quiet[s] && s != seg_end.size() - 1;
            if (s == 2)
                hold_long = 1'b1;
            while (pos < seg_end[s])
            begin
                put_byte(doc[pos]);
                pos++;
            end
        end
        settle();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
